FILE: rtl/core/drbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drbd_pkg
// Shared types and constants of the delta row byte decoder: result layout,
// status and kind codes, row size limits and result queue geometry.
// ----------------------------------------------------------------------------
package drbd_pkg;

    // Row size limits
    localparam int MAX_ROW_BYTES = 16384;
    localparam int SAT_CAP       = MAX_ROW_BYTES + 1;
    localparam int CNT_W         = $clog2(SAT_CAP + 1);
    localparam int START_W       = 14;
    localparam int LEN_W         = 15;

    // Result queue geometry
    localparam int MAX_PUSH   = 2;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_LW    = FIFO_AW + 1;

    // Result kinds
    localparam logic KIND_FILL   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // End of row status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_OVFL  = 2'd2;

    typedef struct packed {
        logic               kind;
        logic [START_W-1:0] start_res;
        logic [LEN_W-1:0]   run_length;
        logic [7:0]         fill_value;
        logic [LEN_W-1:0]   row_length;
        logic [1:0]         status;
        logic               last_of_run;
    } t_res;

    // Results produced by one item: count, then entries in delivery order
    typedef struct packed {
        logic [1:0] n;
        t_res       r0;
        t_res       r1;
    } t_push;

endpackage
`default_nettype wire

FILE: rtl/core/drbd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drbd_in_if
// Compressed byte channel: one stream byte and its end of row mark per item.
// ----------------------------------------------------------------------------
interface drbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       final_byte;

    modport source (output valid, output code_byte, output final_byte, input ready);
    modport sink   (input valid, input code_byte, input final_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/drbd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drbd_out_if
// Result channel: fill commands and end of row reports.
// ----------------------------------------------------------------------------
interface drbd_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [13:0] start_res;
    logic [14:0] run_length;
    logic [7:0]  fill_value;
    logic [14:0] row_length;
    logic [1:0]  status;
    logic        last_of_run;

    modport source (
        output valid, output kind, output start_res, output run_length,
        output fill_value, output row_length, output status, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input kind, input start_res, input run_length,
        input fill_value, input row_length, input status, input last_of_run,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/drbd_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drbd_cfg_if
// Configuration write channel carrying the seed row size.
// ----------------------------------------------------------------------------
interface drbd_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] row_bytes;

    modport source (output valid, output row_bytes, input ready);
    modport sink   (input valid, input row_bytes, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/drbd_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drbd_core
// Input register, command parser state and single pass decode. Each
// registered byte updates the parser and yields up to two results.
// ----------------------------------------------------------------------------
module drbd_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic [7:0]                   i_code,
    input  wire logic                         i_final,
    output logic                              o_in_ready,
    input  wire logic                         i_cfg_we,
    input  wire logic [14:0]                  i_cfg_data,
    input  wire logic [drbd_pkg::FIFO_LW-1:0] i_fifo_level,
    output drbd_pkg::t_push                   o_push
);

    typedef enum logic [2:0] {
        PH_CMD,
        PH_OFF_EXT,
        PH_CNT_EXT,
        PH_RUN_DATA,
        PH_LIT_DATA,
        PH_DRAIN
    } t_phase;

    localparam int CW = drbd_pkg::CNT_W;
    localparam logic [CW-1:0] RUN_OFF_EXT = CW'(3);
    localparam logic [CW-1:0] LIT_OFF_EXT = CW'(15);
    localparam logic [CW-1:0] RUN_CNT_EXT = CW'(33);
    localparam logic [CW-1:0] LIT_CNT_EXT = CW'(8);
    localparam logic [7:0]    EXT_BYTE    = 8'd255;
    localparam logic [CW-1:0] MAX_ROW     = CW'(drbd_pkg::MAX_ROW_BYTES);

    t_phase          r_phase, n_phase;
    logic            r_run_mode, n_run_mode;
    logic [CW-1:0]   r_off, n_off;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_wp, n_wp;
    logic [1:0]      r_err, n_err;
    logic [14:0]     r_row_bytes;
    logic            r_in_valid;
    logic [7:0]      r_code;
    logic            r_final;

    logic            accept;
    logic [CW-1:0]   row_limit;
    logic            hdr_go;
    logic            fill_go;
    logic            report_go;
    logic [CW-1:0]   fill_len;
    logic [CW-1:0]   fill_start;
    logic [1:0]      rep_status;
    logic [CW-1:0]   rep_len;
    logic [CW+1:0]   at_sum;
    logic [CW+1:0]   end_sum;
    logic [4:0]      room_need;
    drbd_pkg::t_res  fill_res;
    drbd_pkg::t_res  rep_res;

    // Saturating extension add
    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [7:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + (CW+1)'(b);
        return (s > (CW+1)'(drbd_pkg::SAT_CAP)) ? CW'(drbd_pkg::SAT_CAP) : s[CW-1:0];
    endfunction

    // Accept only with queue room for this item and the one in flight
    assign room_need  = 5'(i_fifo_level) + (r_in_valid ? 5'(drbd_pkg::MAX_PUSH) : 5'd0)
                      + 5'(drbd_pkg::MAX_PUSH);
    assign o_in_ready = (room_need <= 5'(drbd_pkg::FIFO_DEPTH));
    assign accept     = i_in_valid && o_in_ready;

    // Clamp the configured row size
    assign row_limit = (CW'(r_row_bytes) > MAX_ROW) ? MAX_ROW : CW'(r_row_bytes);

    // Decode the registered byte
    always_comb begin
        n_phase    = r_phase;
        n_run_mode = r_run_mode;
        n_off      = r_off;
        n_cnt      = r_cnt;
        n_wp       = r_wp;
        n_err      = r_err;
        hdr_go     = 1'b0;
        fill_go    = 1'b0;
        report_go  = 1'b0;
        fill_len   = '0;
        fill_start = r_wp;
        rep_status = drbd_pkg::ST_OK;
        rep_len    = '0;
        at_sum     = '0;
        end_sum    = '0;

        if (r_in_valid) begin
            unique case (r_phase)
                PH_CMD: begin
                    if (r_code[7]) begin
                        n_run_mode = 1'b1;
                        n_off      = CW'(r_code[6:5]);
                        n_cnt      = CW'(r_code[4:0]) + CW'(2);
                        if (n_off == RUN_OFF_EXT) begin
                            n_phase = PH_OFF_EXT;
                        end else if (n_cnt == RUN_CNT_EXT) begin
                            n_phase = PH_CNT_EXT;
                        end else begin
                            hdr_go = 1'b1;
                        end
                    end else begin
                        n_run_mode = 1'b0;
                        n_off      = CW'(r_code[6:3]);
                        n_cnt      = CW'(r_code[2:0]) + CW'(1);
                        if (n_off == LIT_OFF_EXT) begin
                            n_phase = PH_OFF_EXT;
                        end else if (n_cnt == LIT_CNT_EXT) begin
                            n_phase = PH_CNT_EXT;
                        end else begin
                            hdr_go = 1'b1;
                        end
                    end
                end
                PH_OFF_EXT: begin
                    n_off = sat_add(r_off, r_code);
                    if (r_code != EXT_BYTE) begin
                        if (r_run_mode ? (r_cnt == RUN_CNT_EXT) : (r_cnt == LIT_CNT_EXT)) begin
                            n_phase = PH_CNT_EXT;
                        end else begin
                            hdr_go = 1'b1;
                        end
                    end
                end
                PH_CNT_EXT: begin
                    n_cnt = sat_add(r_cnt, r_code);
                    if (r_code != EXT_BYTE) begin
                        hdr_go = 1'b1;
                    end
                end
                PH_RUN_DATA: begin
                    fill_go  = 1'b1;
                    fill_len = r_cnt;
                    n_wp     = r_wp + r_cnt;
                    n_phase  = PH_CMD;
                end
                PH_LIT_DATA: begin
                    fill_go  = 1'b1;
                    fill_len = CW'(1);
                    n_wp     = r_wp + CW'(1);
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - CW'(1);
                    end
                    if (n_cnt == '0) begin
                        n_phase = PH_CMD;
                    end
                end
                PH_DRAIN: begin
                    n_phase = PH_DRAIN;
                end
                default: begin
                    n_phase = PH_DRAIN;
                end
            endcase

            // Check a finished header against the row limit
            if (hdr_go) begin
                at_sum  = (CW+2)'(n_wp) + (CW+2)'(n_off);
                end_sum = at_sum + (CW+2)'(n_cnt);
                if (end_sum > (CW+2)'(row_limit)) begin
                    n_err   = drbd_pkg::ST_OVFL;
                    n_phase = PH_DRAIN;
                end else begin
                    n_wp    = at_sum[CW-1:0];
                    n_phase = n_run_mode ? PH_RUN_DATA : PH_LIT_DATA;
                end
            end

            // Report at the end of the row, then clear for the next row
            if (r_final) begin
                report_go = 1'b1;
                rep_len   = n_wp;
                if (n_err == drbd_pkg::ST_OVFL || n_phase == PH_DRAIN) begin
                    rep_status = drbd_pkg::ST_OVFL;
                end else if (n_phase != PH_CMD) begin
                    rep_status = drbd_pkg::ST_TRUNC;
                end else begin
                    rep_status = drbd_pkg::ST_OK;
                end
                n_phase    = PH_CMD;
                n_run_mode = 1'b0;
                n_off      = '0;
                n_cnt      = '0;
                n_wp       = '0;
                n_err      = drbd_pkg::ST_OK;
            end
        end
    end

    // Assemble results in delivery order
    always_comb begin
        fill_res.kind        = drbd_pkg::KIND_FILL;
        fill_res.start_res   = fill_start[drbd_pkg::START_W-1:0];
        fill_res.run_length  = drbd_pkg::LEN_W'(fill_len);
        fill_res.fill_value  = r_code;
        fill_res.row_length  = '0;
        fill_res.status      = drbd_pkg::ST_OK;
        fill_res.last_of_run = !r_final;

        rep_res.kind        = drbd_pkg::KIND_REPORT;
        rep_res.start_res   = '0;
        rep_res.run_length  = '0;
        rep_res.fill_value  = '0;
        rep_res.row_length  = drbd_pkg::LEN_W'(rep_len);
        rep_res.status      = rep_status;
        rep_res.last_of_run = 1'b1;

        o_push.n  = 2'(fill_go) + 2'(report_go);
        o_push.r0 = fill_go ? fill_res : rep_res;
        o_push.r1 = rep_res;
    end

    // Hold parser state, input register and row size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CMD;
            r_run_mode  <= 1'b0;
            r_off       <= '0;
            r_cnt       <= '0;
            r_wp        <= '0;
            r_err       <= drbd_pkg::ST_OK;
            r_row_bytes <= 15'(drbd_pkg::MAX_ROW_BYTES);
            r_in_valid  <= 1'b0;
            r_code      <= '0;
            r_final     <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_run_mode <= n_run_mode;
            r_off      <= n_off;
            r_cnt      <= n_cnt;
            r_wp       <= n_wp;
            r_err      <= n_err;
            r_in_valid <= accept;
            if (accept) begin
                r_code  <= i_code;
                r_final <= i_final;
            end
            if (i_cfg_we) begin
                r_row_bytes <= i_cfg_data;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/drbd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drbd_fifo
// Result queue: takes up to two results per cycle, hands out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module drbd_fifo (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire drbd_pkg::t_push              i_push,
    output drbd_pkg::t_res                    o_head,
    output logic                              o_valid,
    input  wire logic                         i_pop,
    output logic [drbd_pkg::FIFO_LW-1:0]      o_level
);

    localparam int AW = drbd_pkg::FIFO_AW;
    localparam int LW = drbd_pkg::FIFO_LW;

    drbd_pkg::t_res  r_mem [drbd_pkg::FIFO_DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [LW-1:0]   r_level, n_level;
    logic            pop;

    assign o_valid = (r_level != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_level = r_level;
    assign pop     = i_pop && o_valid;

    // Advance pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr + AW'(i_push.n);
        n_rd_ptr = pop ? r_rd_ptr + AW'(1) : r_rd_ptr;
        n_level  = r_level + LW'(i_push.n) - LW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // Store results at the tail
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wr_ptr + AW'(1)] <= i_push.r1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/delta_row_byte_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delta_row_byte_decoder
// Replacement delta row decoder: turns a compressed byte stream into fill
// commands for an external seed row buffer and one report per row.
//
// i_item carries one compressed byte per item with final_byte marking the
// last byte of a row. o_res carries fill commands (start, length, value)
// and, after the final byte, an end of row report with the row length and
// a status (ok, truncated, overflow). i_cfg writes the seed row size; it is
// always ready; the user must write it only while the block is idle, which
// the block itself does not enforce. Each accepted byte is registered and
// decoded in a single pass in the next cycle, and its results are queued;
// the first result is visible at the output once the queue has stored it.
// One byte is taken per cycle as long as the receiver takes one result per
// cycle; a final byte inside a data phase gives two results, a fill and then
// the end of row report.
// The eight entry result queue sets the stall behavior: input ready drops
// when the queue lacks room for two results of the byte in flight and two
// of the next one, so a stalled receiver loses nothing.
// Reset empties the queue, clears the parser and sets the row size to 16384.
// ----------------------------------------------------------------------------
module delta_row_byte_decoder (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    drbd_in_if.sink   i_item,
    drbd_cfg_if.sink  i_cfg,
    drbd_out_if.source o_res
);

    drbd_pkg::t_push                  push;
    drbd_pkg::t_res                   head;
    logic                             head_valid;
    logic [drbd_pkg::FIFO_LW-1:0]     fifo_level;

    assign i_cfg.ready = 1'b1;

    // Parser and input register
    drbd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_item.valid),
        .i_code       (i_item.code_byte),
        .i_final      (i_item.final_byte),
        .o_in_ready   (i_item.ready),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_data   (i_cfg.row_bytes),
        .i_fifo_level (fifo_level),
        .o_push       (push)
    );

    // Result queue
    drbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_head  (head),
        .o_valid (head_valid),
        .i_pop   (o_res.ready),
        .o_level (fifo_level)
    );

    // Drive the result channel from the queue head
    assign o_res.valid       = head_valid;
    assign o_res.kind        = head.kind;
    assign o_res.start_res   = head.start_res;
    assign o_res.run_length  = head.run_length;
    assign o_res.fill_value  = head.fill_value;
    assign o_res.row_length  = head.row_length;
    assign o_res.status      = head.status;
    assign o_res.last_of_run = head.last_of_run;

    // Queue never overfills
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_level <= drbd_pkg::FIFO_LW'(drbd_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    // A fill always covers at least one byte and carries no status
    a_fill_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == drbd_pkg::KIND_FILL)
        |-> (o_res.run_length != '0 && o_res.status == drbd_pkg::ST_OK))
        else $error("malformed fill command");

    // A report always ends the results of its byte with a defined status
    a_report_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == drbd_pkg::KIND_REPORT)
        |-> (o_res.last_of_run && (o_res.status == drbd_pkg::ST_OK
             || o_res.status == drbd_pkg::ST_TRUNC || o_res.status == drbd_pkg::ST_OVFL)))
        else $error("malformed end of row report");

    // An empty result queue always admits input
    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fifo_level == '0) |-> i_item.ready)
        else $error("input stalled with an empty result queue");

endmodule
`default_nettype wire
